// File: rtl/sfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the serial frame deframer.
package sfd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned ID_W        = 16;
    localparam int unsigned NIB_W       = 4;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned CFG_ADDR_W  = 1;
    localparam int unsigned OUT_BITS    = 65;
    localparam int unsigned OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [BYTE_W:0]   MAX_PAYLOAD  = 9'd255;
    localparam logic [BYTE_W-1:0] START_RESET  = 8'd91;
    localparam logic [BYTE_W-1:0] STOP_RESET   = 8'd93;

    localparam logic [CFG_ADDR_W-1:0] REG_START_MARKER = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STOP_MARKER  = 1'd1;

    typedef enum logic [3:0] {
        PH_HUNT = 4'd0,
        PH_IDH  = 4'd1,
        PH_IDL  = 4'd2,
        PH_REQ  = 4'd3,
        PH_EXT  = 4'd4,
        PH_CODE = 4'd5,
        PH_SUB  = 4'd6,
        PH_LEN  = 4'd7,
        PH_DATA = 4'd8,
        PH_STOP = 4'd9
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD_END = 2'd1,
        KIND_BAD_END  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic [ID_W-1:0]   msg_id;
        logic              request_flag;
        logic [BYTE_W-1:0] ext_byte;
        logic [BYTE_W-1:0] code_byte;
        logic [NIB_W-1:0]  sub_high;
        logic [NIB_W-1:0]  sub_low;
        logic [BYTE_W-1:0] frame_length;
        logic              last;
    } result_t;

    function automatic logic [OUT_DATA_W-1:0] pack_data(input result_t r);
        logic [OUT_DATA_W-1:0] d;
        d = '0;
        d[7:0]   = r.payload_byte;
        d[15:8]  = r.payload_index;
        d[31:16] = r.msg_id;
        d[32]    = r.request_flag;
        d[40:33] = r.ext_byte;
        d[48:41] = r.code_byte;
        d[52:49] = r.sub_high;
        d[56:53] = r.sub_low;
        d[64:57] = r.frame_length;
        return d;
    endfunction

endpackage

// File: rtl/sfd_parser.sv
`timescale 1ns / 1ps
// Input register, marker registers and frame parsing state machine.
module sfd_parser
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [sfd_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [sfd_pkg::BYTE_W-1:0]             cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [sfd_pkg::BYTE_W-1:0]             in_byte,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output sfd_pkg::result_t                       res
);

    logic [sfd_pkg::BYTE_W-1:0] start_reg, start_next;
    logic [sfd_pkg::BYTE_W-1:0] stop_reg, stop_next;

    logic                       byte_valid_reg, byte_valid_next;
    logic [sfd_pkg::BYTE_W-1:0] byte_reg, byte_next;

    sfd_pkg::phase_t            phase_reg, phase_next;
    logic [sfd_pkg::ID_W-1:0]   id_reg, id_next;
    logic                       req_reg, req_next;
    logic [sfd_pkg::BYTE_W-1:0] ext_reg, ext_next;
    logic [sfd_pkg::BYTE_W-1:0] code_reg, code_next;
    logic [sfd_pkg::BYTE_W-1:0] sub_reg, sub_next;
    logic [sfd_pkg::BYTE_W-1:0] len_reg, len_next;
    logic [sfd_pkg::BYTE_W-1:0] count_reg, count_next;

    logic                       has_result;
    logic                       advance;
    logic [sfd_pkg::BYTE_W-1:0] count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg      <= sfd_pkg::START_RESET;
            stop_reg       <= sfd_pkg::STOP_RESET;
            byte_valid_reg <= 1'b0;
            phase_reg      <= sfd_pkg::PH_HUNT;
            id_reg         <= '0;
            req_reg        <= 1'b0;
            ext_reg        <= '0;
            code_reg       <= '0;
            sub_reg        <= '0;
            len_reg        <= '0;
            count_reg      <= '0;
        end
        else
        begin
            start_reg      <= start_next;
            stop_reg       <= stop_next;
            byte_valid_reg <= byte_valid_next;
            phase_reg      <= phase_next;
            id_reg         <= id_next;
            req_reg        <= req_next;
            ext_reg        <= ext_next;
            code_reg       <= code_next;
            sub_reg        <= sub_next;
            len_reg        <= len_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    // config port
    always_comb
    begin
        start_next = start_reg;
        stop_next  = stop_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                sfd_pkg::REG_START_MARKER: start_next = cfg_wdata;
                sfd_pkg::REG_STOP_MARKER:  stop_next  = cfg_wdata;
                default:                   ;
            endcase
        end
    end

    assign has_result = byte_valid_reg &&
                        (phase_reg == sfd_pkg::PH_DATA || phase_reg == sfd_pkg::PH_STOP);
    assign advance    = byte_valid_reg && (!has_result || res_ready);
    assign in_ready   = !byte_valid_reg || advance;
    assign res_valid  = has_result && res_ready;
    assign count_inc  = count_reg + 8'd1;

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        byte_next       = byte_reg;
        if (in_ready)
        begin
            byte_valid_next = in_valid;
            if (in_valid)
            begin
                byte_next = in_byte;
            end
        end
    end

    // next state and result
    always_comb
    begin
        phase_next = phase_reg;
        id_next    = id_reg;
        req_next   = req_reg;
        ext_next   = ext_reg;
        code_next  = code_reg;
        sub_next   = sub_reg;
        len_next   = len_reg;
        count_next = count_reg;

        res.kind          = sfd_pkg::KIND_PAYLOAD;
        res.payload_byte  = '0;
        res.payload_index = '0;
        res.msg_id        = id_reg;
        res.request_flag  = req_reg;
        res.ext_byte      = ext_reg;
        res.code_byte     = code_reg;
        res.sub_high      = sub_reg[7:4];
        res.sub_low       = sub_reg[3:0];
        res.frame_length  = len_reg;
        res.last          = 1'b0;

        case (phase_reg)
            sfd_pkg::PH_DATA:
            begin
                res.payload_byte  = byte_reg;
                res.payload_index = count_reg;
            end
            sfd_pkg::PH_STOP:
            begin
                res.kind = (byte_reg == stop_reg) ? sfd_pkg::KIND_GOOD_END
                                                  : sfd_pkg::KIND_BAD_END;
                res.last = 1'b1;
            end
            default: ;
        endcase

        if (advance)
        begin
            case (phase_reg)
                sfd_pkg::PH_IDH:
                begin
                    id_next    = {byte_reg, id_reg[7:0]};
                    phase_next = sfd_pkg::PH_IDL;
                end
                sfd_pkg::PH_IDL:
                begin
                    id_next    = {id_reg[15:8], byte_reg};
                    phase_next = sfd_pkg::PH_REQ;
                end
                sfd_pkg::PH_REQ:
                begin
                    req_next   = (byte_reg != 8'd0);
                    phase_next = sfd_pkg::PH_EXT;
                end
                sfd_pkg::PH_EXT:
                begin
                    ext_next   = byte_reg;
                    phase_next = sfd_pkg::PH_CODE;
                end
                sfd_pkg::PH_CODE:
                begin
                    code_next  = byte_reg;
                    phase_next = sfd_pkg::PH_SUB;
                end
                sfd_pkg::PH_SUB:
                begin
                    sub_next   = byte_reg;
                    phase_next = sfd_pkg::PH_LEN;
                end
                sfd_pkg::PH_LEN:
                begin
                    len_next   = byte_reg;
                    count_next = '0;
                    if ({1'b0, byte_reg} > sfd_pkg::MAX_PAYLOAD)
                        phase_next = sfd_pkg::PH_HUNT;
                    else if (byte_reg == 8'd0)
                        phase_next = sfd_pkg::PH_STOP;
                    else
                        phase_next = sfd_pkg::PH_DATA;
                end
                sfd_pkg::PH_DATA:
                begin
                    count_next = count_inc;
                    if (count_inc == len_reg)
                        phase_next = sfd_pkg::PH_STOP;
                end
                sfd_pkg::PH_STOP:
                begin
                    count_next = '0;
                    phase_next = sfd_pkg::PH_HUNT;
                end
                default:
                begin
                    phase_next = (byte_reg == start_reg) ? sfd_pkg::PH_IDH
                                                         : sfd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sfd_pkg::PH_DATA |-> count_reg < len_reg)
        else $error("payload count reached frame length while in data phase");

    a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
        has_result && !res_ready |=> byte_valid_reg && $stable(byte_reg)
                                     && $stable(phase_reg))
        else $error("pending byte lost while result path stalled");

endmodule

// File: rtl/sfd_out_buf.sv
`timescale 1ns / 1ps
// Output register with skid stage for the result channel.
module sfd_out_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             ready,
    input  sfd_pkg::result_t din,
    output logic             out_valid,
    input  logic             out_ready,
    output sfd_pkg::result_t dout
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    sfd_pkg::result_t main_reg, main_next;
    sfd_pkg::result_t skid_reg, skid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_valid_reg && out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_next = din;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (!main_valid_reg)
        begin
            if (push)
            begin
                main_next       = din;
                main_valid_next = 1'b1;
            end
        end
        else if (push)
        begin
            skid_next       = din;
            skid_valid_next = 1'b1;
        end
    end

    assign ready     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign dout      = main_reg;

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into full buffer");

endmodule

// File: rtl/serial_frame_deframer.sv
`timescale 1ns / 1ps
// Top level of the serial frame deframer.
//
// Byte stream in on s_axis (tdata = one received byte), frame results out
// on m_axis. Each transaction on m_axis is either a payload byte (tuser =
// payload, tlast = 0) or the frame end (tuser = good or bad stop, tlast = 1).
// Header fields and frame length ride along in tdata on every result.
// Markers are set through cfg_we/cfg_addr/cfg_wdata (0 start, 1 stop).
//
// Throughput: one byte per cycle; s_axis_tready stays high while the
// output side keeps up. A result passes the input register, then the
// output register, before it is valid on m_axis. Header and length
// bytes produce no result.
//
// Reset: asynchronous, active low; the parser returns to start hunting
// and the markers go to 91 and 93.
// Stall: when m_axis_tready is low, a skid entry absorbs one more result,
// then the input register holds and s_axis_tready drops until the sink
// drains the output.
module serial_frame_deframer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sfd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [sfd_pkg::BYTE_W-1:0]         cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sfd_pkg::BYTE_W-1:0]         s_axis_tdata,  // rx_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // payload_byte, payload_index, msg_id, request_flag, ext_byte,
    // code_byte, sub_high, sub_low, frame_length, zero fill
    output logic [sfd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [sfd_pkg::KIND_W-1:0]         m_axis_tuser,  // kind
    output logic                               m_axis_tlast
);

    logic             res_valid;
    logic             res_ready;
    sfd_pkg::result_t res;
    sfd_pkg::result_t out_res;

    sfd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    sfd_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .ready     (res_ready),
        .din       (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .dout      (out_res)
    );

    assign m_axis_tdata = sfd_pkg::pack_data(out_res);
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule
